### rtl/core/assert_macros.svh
// assertion macros shared by the dfa state minimizer rtl
// depends on nothing; each use sits on a line of its own
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define DSM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define DSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/dsm_pkg.sv
// shared types and codes of the dfa state minimizer
// no dependencies
`default_nettype none
package dsm_pkg;
    typedef logic [1:0]  op_t;
    typedef logic [5:0]  state_idx_t;
    typedef logic [6:0]  count_t;
    typedef logic [6:0]  symbol_t;
    typedef logic [6:0]  target_t;
    typedef logic [7:0]  action_t;
    typedef logic [15:0] token_t;

    localparam op_t OP_LOAD_TRANS = 2'd0;
    localparam op_t OP_LOAD_LABEL = 2'd1;
    localparam op_t OP_RUN        = 2'd2;

    localparam int  LABEL_W       = 24;
    localparam int  STATE_LIMIT   = 64;
    localparam logic REG_STATE_COUNT = 1'b0;
endpackage
`default_nettype wire

### rtl/core/dsm_in_if.sv
// input item channel of the dfa state minimizer
// depends on dsm_pkg
`default_nettype none
interface dsm_in_if;
    import dsm_pkg::*;
    logic       valid;
    logic       ready;
    op_t        operation;
    state_idx_t state_index;
    symbol_t    symbol;
    target_t    target_state;
    action_t    action_code;
    token_t     token_code;

    modport source (output valid, operation, state_index, symbol, target_state,
                    action_code, token_code, input ready);
    modport sink (input valid, operation, state_index, symbol, target_state,
                  action_code, token_code, output ready);
endinterface
`default_nettype wire

### rtl/core/dsm_out_if.sv
// result channel of the dfa state minimizer
// depends on dsm_pkg
`default_nettype none
interface dsm_out_if;
    import dsm_pkg::*;
    logic       valid;
    logic       ready;
    state_idx_t original_state;
    state_idx_t group_number;
    count_t     group_total;
    logic       last;

    modport source (output valid, original_state, group_number, group_total, last,
                    input ready);
    modport sink (input valid, original_state, group_number, group_total, last,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/dsm_ram.sv
// one write port, two registered read ports synchronous ram
// no dependencies
`default_nettype none
module dsm_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [W-1:0]             rdata_a,
    output logic      [W-1:0]             rdata_b
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end
endmodule
`default_nettype wire

### rtl/core/dsm_ctrl.sv
// sequencer for loading, partition refinement and result output
// depends on dsm_pkg, dsm_ram, dsm_in_if, dsm_out_if, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module dsm_ctrl #(
    parameter int MAX_STATES    = 64,
    parameter int ALPHABET_SIZE = 128
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dsm_pkg::count_t state_count,
    dsm_in_if.sink               items,
    dsm_out_if.source            results
);
    import dsm_pkg::*;

    localparam int NS  = (MAX_STATES < STATE_LIMIT) ? MAX_STATES : STATE_LIMIT;
    localparam int SAW = $clog2(NS);
    localparam int CW  = $clog2(ALPHABET_SIZE);
    localparam int TAW = $clog2(NS * ALPHABET_SIZE);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT_I, S_INIT_CMP, S_INIT_GRP, S_PASS, S_SCAN_RD, S_SCAN_CHK,
        S_ROW_RD, S_ROW_TGT, S_ROW_CMP, S_GRP_END, S_OUT_RD, S_OUT_LD, S_OUT_HOLD
    } fsm_t;

    fsm_t       state_reg;
    count_t     n_reg;
    state_idx_t i_reg;
    state_idx_t j_reg;
    state_idx_t s_reg;
    state_idx_t first_reg;
    count_t     g_reg;
    count_t     groups_reg;
    logic [CW-1:0] c_reg;
    logic       found_reg;
    logic       fresh_reg;
    logic       split_reg;
    logic       out_valid_reg;
    state_idx_t out_orig_reg;
    state_idx_t out_group_reg;
    count_t     out_total_reg;
    logic       out_last_reg;

    // memory ports
    logic               t_we, t_re;
    logic [TAW-1:0]     t_waddr, t_raddr_a, t_raddr_b;
    target_t            t_rd_a, t_rd_b;
    logic               l_we, l_re;
    logic [SAW-1:0]     l_waddr, l_raddr_a, l_raddr_b;
    logic [LABEL_W-1:0] l_wdata, l_rd_a, l_rd_b;
    logic               g_we, g_re;
    logic [SAW-1:0]     g_waddr, g_raddr_a, g_raddr_b;
    state_idx_t         g_wdata, g_rd_a, g_rd_b;

    logic   accept;
    logic   load_ok;
    logic   sym_ok;
    logic   i_last;
    logic   s_last;
    logic   none_a, none_b, differ;
    count_t n_clamped;

    assign accept  = items.valid && items.ready;
    assign load_ok = int'(items.state_index) < NS;
    assign sym_ok  = int'(items.symbol) < ALPHABET_SIZE;
    assign i_last  = ({1'b0, i_reg} == (n_reg - 7'd1));
    assign s_last  = ({1'b0, s_reg} == (n_reg - 7'd1));
    assign none_a  = t_rd_a >= n_reg;
    assign none_b  = t_rd_b >= n_reg;
    // two none targets are equal; a live target differs by group only
    assign differ  = (none_a != none_b) || (!none_a && !none_b && (g_rd_a != g_rd_b));

    always_comb
    begin
        if (state_count == 7'd0)
        begin
            n_clamped = 7'd1;
        end
        else if (int'(state_count) > NS)
        begin
            n_clamped = 7'(NS);
        end
        else
        begin
            n_clamped = state_count;
        end
    end

    // memory control from the current state
    always_comb
    begin
        t_we      = accept && (items.operation == OP_LOAD_TRANS) && load_ok && sym_ok;
        t_waddr   = TAW'(int'(items.state_index) * ALPHABET_SIZE + int'(items.symbol));
        t_re      = (state_reg == S_ROW_RD);
        t_raddr_a = TAW'(int'(first_reg) * ALPHABET_SIZE + int'(c_reg));
        t_raddr_b = TAW'(int'(s_reg) * ALPHABET_SIZE + int'(c_reg));

        l_we      = accept && (items.operation == OP_LOAD_LABEL) && load_ok;
        l_waddr   = items.state_index[SAW-1:0];
        l_wdata   = {items.action_code, items.token_code};
        l_re      = (state_reg == S_INIT_I);
        l_raddr_a = i_reg[SAW-1:0];
        l_raddr_b = j_reg[SAW-1:0];

        g_we      = 1'b0;
        g_waddr   = i_reg[SAW-1:0];
        g_wdata   = groups_reg[5:0];
        g_re      = 1'b0;
        g_raddr_a = s_reg[SAW-1:0];
        g_raddr_b = t_rd_b[SAW-1:0];
        case (state_reg)
            S_INIT_I:
            begin
                g_we = (j_reg == i_reg);
            end
            S_INIT_CMP:
            begin
                g_re      = (l_rd_a == l_rd_b);
                g_raddr_a = j_reg[SAW-1:0];
            end
            S_INIT_GRP:
            begin
                g_we    = 1'b1;
                g_wdata = g_rd_a;
            end
            S_SCAN_RD, S_OUT_RD:
            begin
                g_re = 1'b1;
            end
            S_ROW_TGT:
            begin
                g_re      = 1'b1;
                g_raddr_a = t_rd_a[SAW-1:0];
            end
            S_ROW_CMP:
            begin
                g_we    = differ;
                g_waddr = s_reg[SAW-1:0];
            end
            default:
            begin
                g_we = 1'b0;
            end
        endcase
    end

    dsm_ram #(.W($bits(target_t)), .DEPTH(NS * ALPHABET_SIZE)) u_trans (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(items.target_state),
        .re(t_re), .raddr_a(t_raddr_a), .raddr_b(t_raddr_b),
        .rdata_a(t_rd_a), .rdata_b(t_rd_b)
    );

    dsm_ram #(.W(LABEL_W), .DEPTH(NS)) u_label (
        .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
        .re(l_re), .raddr_a(l_raddr_a), .raddr_b(l_raddr_b),
        .rdata_a(l_rd_a), .rdata_b(l_rd_b)
    );

    dsm_ram #(.W($bits(state_idx_t)), .DEPTH(NS)) u_group (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .re(g_re), .raddr_a(g_raddr_a), .raddr_b(g_raddr_b),
        .rdata_a(g_rd_a), .rdata_b(g_rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= 7'd1;
            i_reg         <= '0;
            j_reg         <= '0;
            s_reg         <= '0;
            first_reg     <= '0;
            g_reg         <= '0;
            groups_reg    <= '0;
            c_reg         <= '0;
            found_reg     <= 1'b0;
            fresh_reg     <= 1'b0;
            split_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_orig_reg  <= '0;
            out_group_reg <= '0;
            out_total_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (items.operation == OP_RUN))
                    begin
                        n_reg      <= n_clamped;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        groups_reg <= '0;
                        state_reg  <= S_INIT_I;
                    end
                end
                S_INIT_I:
                begin
                    if (j_reg == i_reg)
                    begin
                        groups_reg <= groups_reg + 7'd1;
                        if (i_last)
                        begin
                            g_reg     <= '0;
                            split_reg <= 1'b0;
                            state_reg <= S_PASS;
                        end
                        else
                        begin
                            i_reg <= i_reg + 6'd1;
                            j_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_INIT_CMP;
                    end
                end
                S_INIT_CMP:
                begin
                    if (l_rd_a == l_rd_b)
                    begin
                        state_reg <= S_INIT_GRP;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 6'd1;
                        state_reg <= S_INIT_I;
                    end
                end
                S_INIT_GRP:
                begin
                    if (i_last)
                    begin
                        g_reg     <= '0;
                        split_reg <= 1'b0;
                        state_reg <= S_PASS;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 6'd1;
                        j_reg     <= '0;
                        state_reg <= S_INIT_I;
                    end
                end
                S_PASS:
                begin
                    if (g_reg == groups_reg)
                    begin
                        if (split_reg)
                        begin
                            g_reg     <= '0;
                            split_reg <= 1'b0;
                        end
                        else
                        begin
                            s_reg     <= '0;
                            state_reg <= S_OUT_RD;
                        end
                    end
                    else
                    begin
                        s_reg     <= '0;
                        found_reg <= 1'b0;
                        fresh_reg <= 1'b0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (({1'b0, g_rd_a} == g_reg) && found_reg)
                    begin
                        c_reg     <= '0;
                        state_reg <= S_ROW_RD;
                    end
                    else
                    begin
                        if ({1'b0, g_rd_a} == g_reg)
                        begin
                            first_reg <= s_reg;
                            found_reg <= 1'b1;
                        end
                        if (s_last)
                        begin
                            state_reg <= S_GRP_END;
                        end
                        else
                        begin
                            s_reg     <= s_reg + 6'd1;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                end
                S_ROW_RD:
                begin
                    state_reg <= S_ROW_TGT;
                end
                S_ROW_TGT:
                begin
                    state_reg <= S_ROW_CMP;
                end
                S_ROW_CMP:
                begin
                    if (differ || (c_reg == CW'(ALPHABET_SIZE - 1)))
                    begin
                        if (differ)
                        begin
                            fresh_reg <= 1'b1;
                        end
                        if (s_last)
                        begin
                            state_reg <= S_GRP_END;
                        end
                        else
                        begin
                            s_reg     <= s_reg + 6'd1;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        c_reg     <= c_reg + CW'(1);
                        state_reg <= S_ROW_RD;
                    end
                end
                S_GRP_END:
                begin
                    // split-off members were already written with the new number
                    if (fresh_reg)
                    begin
                        groups_reg <= groups_reg + 7'd1;
                        split_reg  <= 1'b1;
                    end
                    g_reg     <= g_reg + 7'd1;
                    state_reg <= S_PASS;
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_LD;
                end
                S_OUT_LD:
                begin
                    out_valid_reg <= 1'b1;
                    out_orig_reg  <= s_reg;
                    out_group_reg <= g_rd_a;
                    out_total_reg <= groups_reg;
                    out_last_reg  <= s_last;
                    state_reg     <= S_OUT_HOLD;
                end
                S_OUT_HOLD:
                begin
                    if (results.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            s_reg     <= s_reg + 6'd1;
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign items.ready            = (state_reg == S_IDLE);
    assign results.valid          = out_valid_reg;
    assign results.original_state = out_orig_reg;
    assign results.group_number   = out_group_reg;
    assign results.group_total    = out_total_reg;
    assign results.last           = out_last_reg;

    `DSM_ASSERT_IMPLY(a_ready_no_result, clk, rst_n, items.ready, !results.valid, "input taken while a result waits")
    `DSM_ASSERT_IMPLY(a_groups_bounded, clk, rst_n, state_reg != S_IDLE, groups_reg <= n_reg, "group count above state count")
    `DSM_ASSERT_NEXT(a_last_frees_input, clk, rst_n, results.valid && results.ready && results.last, items.ready, "block busy after final result")
endmodule
`default_nettype wire

### rtl/core/dfa_state_minimizer_top.sv
// dfa state minimizer: apb register for the state count and the sequencer
// depends on dsm_pkg, dsm_in_if, dsm_out_if, dsm_ctrl
//
// usage
//   items channel: operation 0 stores one transition (state_index, symbol,
//   target_state; a target at or above the state count means no transition),
//   operation 1 stores the action and token label of a state, operation 2
//   runs the minimization, operation 3 is dropped. loads and dropped items
//   may follow back to back, each taken while the sequencer idles.
//   a run emits one transfer per state on the results channel, in ascending
//   state order, with the group number, the group total and last on the
//   final state. no new item is taken until the final result is transferred.
//   during a run, initial grouping compares state labels pair by pair, each
//   refinement pass scans every group over all states, and a row compare
//   goes symbol by symbol (transition ram read, then group ram read of both
//   targets, then compare), stopping at the first mismatch.
//   each result is read from the group ram, loaded into the output register
//   and held until taken; a stalled receiver holds it and the sequencer waits.
//   reset: the state count register goes to 1, the sequencer idles; the
//   table and label memories are not cleared and must be loaded before use.
//   the state count register sits at byte address 0 and must be written only
//   while the block is idle; the block itself does not enforce this.
`default_nettype none
module dfa_state_minimizer_top #(
    parameter int MAX_STATES    = 64,
    parameter int ALPHABET_SIZE = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    dsm_in_if.sink           items,
    dsm_out_if.source        results,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import dsm_pkg::*;

    count_t state_count_reg;
    logic   cfg_write;

    // register index is the word address
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg <= 7'd1;
        end
        else if (cfg_write && (paddr[2] == REG_STATE_COUNT))
        begin
            state_count_reg <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_STATE_COUNT) ? {25'd0, state_count_reg} : 32'd0;

    dsm_ctrl #(
        .MAX_STATES(MAX_STATES),
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .state_count(state_count_reg),
        .items(items),
        .results(results)
    );
endmodule
`default_nettype wire
